[src/swd_pkg.sv]
// Shared types and constants for the scrolling window descriptor generator.
// Depends on nothing; every other file imports it.
package swd_pkg;

  // Screen geometry.
  localparam int SCREEN_COLUMNS = 128;
  localparam int PAGES          = 8;

  // Field widths.
  localparam int PAGE_W     = 3;
  localparam int COL_W      = 8;
  localparam int ADDR_W     = 26;
  localparam int IMG_W      = 16;
  localparam int MARGIN_W   = 10;
  localparam int RATE_W     = 8;
  localparam int ACTION_W   = 2;
  localparam int BASE_W     = 24;
  localparam int START_W    = 17;
  localparam int POS_W      = 18;
  localparam int OFF_W      = 17;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 24;

  // Width of the signed working values in the frame arithmetic.
  localparam int CALC_W = 20;

  // Input commands.
  typedef enum logic [0:0] {
    CMD_RESTART = 1'b0,
    CMD_TICK    = 1'b1
  } cmd_e;

  // Behavior at the right end of the image.
  typedef enum logic [ACTION_W-1:0] {
    END_ONESHOT = 2'd0,
    END_LOOP    = 2'd1,
    END_REVERSE = 2'd2
  } end_action_e;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 4'd0,
    REG_LEFT_MARGIN  = 4'd1,
    REG_RIGHT_MARGIN = 4'd2,
    REG_LEFT_HOLD    = 4'd3,
    REG_RIGHT_HOLD   = 4'd4,
    REG_INITIAL_RATE = 4'd5,
    REG_END_ACTION   = 4'd6,
    REG_DATA_BASE    = 4'd7
  } reg_idx_e;

  // Current register contents.
  typedef struct packed {
    logic [IMG_W-1:0]         image_width;
    logic [MARGIN_W-1:0]      left_margin;
    logic [MARGIN_W-1:0]      right_margin;
    logic [MARGIN_W-1:0]      left_hold;
    logic [MARGIN_W-1:0]      right_hold;
    logic signed [RATE_W-1:0] initial_rate;
    logic [ACTION_W-1:0]      end_action;
    logic [BASE_W-1:0]        data_base;
  } cfg_t;

  // Frame geometry handed from the frame unit to the page sequencer.
  typedef struct packed {
    logic              load;
    logic [ADDR_W-1:0] src_addr;
    logic [COL_W-1:0]  dest_column;
    logic [COL_W-1:0]  copy_width;
    logic              stopped;
  } frame_desc_t;

endpackage

[src/swd_intf.sv]
// Handshake channel interfaces of the scrolling window descriptor generator.
// Depends on swd_pkg for the field widths.

// Command input channel.
interface swd_in_if import swd_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [0:0]          command;
  logic [START_W-1:0]  start_position;

  modport source (output valid, output command, output start_position, input ready);
  modport sink   (input valid, input command, input start_position, output ready);
endinterface

// Copy descriptor output channel.
interface swd_out_if import swd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [PAGE_W-1:0] page_index;
  logic [ADDR_W-1:0] source_address;
  logic [COL_W-1:0]  dest_column;
  logic [COL_W-1:0]  copy_width;
  logic              last_page;
  logic              stopped;

  modport source (output valid, output page_index, output source_address,
                  output dest_column, output copy_width, output last_page,
                  output stopped, input ready);
  modport sink   (input valid, input page_index, input source_address,
                  input dest_column, input copy_width, input last_page,
                  input stopped, output ready);
endinterface

// Configuration write channel.
interface swd_cfg_if import swd_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[src/swd_cfg_regs.sv]
// Configuration register file of the scrolling window descriptor generator.
// Depends on swd_pkg and the swd_cfg_if channel interface.
module swd_cfg_regs import swd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  swd_cfg_if.sink   cfg_i,
  output cfg_t      regs_o
);

  cfg_t regs_q;

  // Writes are always taken; unknown indexes are dropped.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs_q.image_width  <= IMG_W'(128);
      regs_q.left_margin  <= '0;
      regs_q.right_margin <= '0;
      regs_q.left_hold    <= '0;
      regs_q.right_hold   <= '0;
      regs_q.initial_rate <= RATE_W'(1);
      regs_q.end_action   <= END_ONESHOT;
      regs_q.data_base    <= '0;
    end else if (cfg_i.valid && cfg_i.ready) begin
      unique case (cfg_i.index)
        REG_IMAGE_WIDTH:  regs_q.image_width  <= cfg_i.data[IMG_W-1:0];
        REG_LEFT_MARGIN:  regs_q.left_margin  <= cfg_i.data[MARGIN_W-1:0];
        REG_RIGHT_MARGIN: regs_q.right_margin <= cfg_i.data[MARGIN_W-1:0];
        REG_LEFT_HOLD:    regs_q.left_hold    <= cfg_i.data[MARGIN_W-1:0];
        REG_RIGHT_HOLD:   regs_q.right_hold   <= cfg_i.data[MARGIN_W-1:0];
        REG_INITIAL_RATE: regs_q.initial_rate <= $signed(cfg_i.data[RATE_W-1:0]);
        REG_END_ACTION:   regs_q.end_action   <= cfg_i.data[ACTION_W-1:0];
        REG_DATA_BASE:    regs_q.data_base    <= cfg_i.data[BASE_W-1:0];
        default: ;
      endcase
    end
  end

  assign regs_o = regs_q;

endmodule

[src/swd_frame.sv]
// Frame unit: input register, scroll state, clamping, copy geometry and the
// position advance with end handling. Depends on swd_pkg and swd_in_if.
module swd_frame import swd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  swd_in_if.sink      in_i,
  input  cfg_t        regs_i,
  input  logic        seq_free_i,
  output frame_desc_t desc_o
);

  localparam logic signed [CALC_W-1:0] SC_S = CALC_W'(SCREEN_COLUMNS);

  // Input register.
  logic                      in_vld_q;
  cmd_e                      cmd_q;
  logic signed [START_W-1:0] spos_q;

  // Scroll state.
  logic signed [POS_W-1:0]  position_q, position_d;
  logic signed [RATE_W-1:0] rate_q, rate_d;
  logic                     halted_q, halted_d;

  logic take;
  logic emit;

  // Combinational frame results.
  logic signed [CALC_W-1:0] clamp_s;
  logic [OFF_W-1:0]         offset;
  logic [COL_W-1:0]         cw_sat;
  logic [COL_W-1:0]         dest;

  // The held item leaves when it needs no descriptors or the sequencer frees up.
  assign take = in_vld_q && ((cmd_q == CMD_RESTART) || halted_q || seq_free_i);
  assign emit = take && (cmd_q == CMD_TICK) && !halted_q;
  assign in_i.ready = !in_vld_q || take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_i.ready) begin
      in_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      cmd_q  <= cmd_e'(in_i.command);
      spos_q <= $signed(in_i.start_position);
    end
  end

  // Clamp, geometry, advance and end handling.
  always_comb begin
    logic signed [CALC_W-1:0] pos_s, lm_s, rm_s, lh_s, rh_s, w_s;
    logic signed [CALC_W-1:0] lo_b, hi_b, c1, cw_raw, np_s, right_lim;

    pos_s = CALC_W'(position_q);
    w_s   = $signed(CALC_W'(regs_i.image_width));
    lm_s  = $signed(CALC_W'(regs_i.left_margin));
    rm_s  = $signed(CALC_W'(regs_i.right_margin));
    lh_s  = $signed(CALC_W'(regs_i.left_hold));
    rh_s  = $signed(CALC_W'(regs_i.right_hold));

    // Keep the window between the blank margins; the upper bound wins.
    lo_b    = -lm_s;
    hi_b    = w_s + rm_s - SC_S;
    c1      = (pos_s < lo_b) ? lo_b : pos_s;
    clamp_s = (c1 > hi_b) ? hi_b : c1;

    // Copy geometry.
    offset = clamp_s[CALC_W-1] ? '0 : clamp_s[OFF_W-1:0];
    cw_raw = clamp_s[CALC_W-1] ? (SC_S + clamp_s)
                               : (w_s - $signed(CALC_W'(offset)));
    if (cw_raw > SC_S) begin
      cw_sat = COL_W'(SCREEN_COLUMNS);
    end else if (cw_raw[CALC_W-1]) begin
      cw_sat = '0;
    end else begin
      cw_sat = cw_raw[COL_W-1:0];
    end
    dest = clamp_s[CALC_W-1] ? (COL_W'(SCREEN_COLUMNS) - cw_sat) : '0;

    // Advance the raw position, then bounce at the left end.
    rate_d   = rate_q;
    halted_d = halted_q;
    np_s     = pos_s + CALC_W'(rate_q);
    if (np_s < -(lh_s + lm_s)) begin
      np_s   = lo_b;
      rate_d = -rate_d;
    end

    // Right end action.
    right_lim = w_s - SC_S + rh_s + rm_s;
    if (np_s > right_lim) begin
      case (regs_i.end_action)
        END_LOOP: begin
          np_s = lo_b;
        end
        END_REVERSE: begin
          np_s   = hi_b;
          rate_d = -rate_d;
        end
        END_ONESHOT: begin
          halted_d = 1'b1;
        end
        default: begin
          halted_d = 1'b1;
        end
      endcase
    end
    position_d = np_s[POS_W-1:0];

    // A restart overrides all of the above.
    if (cmd_q == CMD_RESTART) begin
      position_d = POS_W'(spos_q);
      rate_d     = regs_i.initial_rate;
      halted_d   = 1'b0;
    end
  end

  // A tick absorbed while stopped leaves the scroll state alone.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      position_q <= '0;
      rate_q     <= RATE_W'(1);
      halted_q   <= 1'b0;
    end else if (take && ((cmd_q == CMD_RESTART) || !halted_q)) begin
      position_q <= position_d;
      rate_q     <= rate_d;
      halted_q   <= halted_d;
    end
  end

  // Frame geometry for the page sequencer.
  assign desc_o.load        = emit;
  assign desc_o.src_addr    = ADDR_W'(regs_i.data_base) + ADDR_W'(offset);
  assign desc_o.dest_column = dest;
  assign desc_o.copy_width  = cw_sat;
  assign desc_o.stopped     = halted_d;

endmodule

[src/swd_page_seq.sv]
// Page sequencer: holds one frame's geometry and sends one copy descriptor
// per display page. Depends on swd_pkg and swd_out_if.
module swd_page_seq import swd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  frame_desc_t desc_i,
  input  logic [IMG_W-1:0] stride_i,
  output logic        free_o,
  swd_out_if.source   out_o
);

  logic              busy_q;
  logic [PAGE_W-1:0] page_q;
  logic [ADDR_W-1:0] addr_q;
  logic [COL_W-1:0]  dest_q;
  logic [COL_W-1:0]  cw_q;
  logic              stopped_q;

  logic last;
  logic xfer;

  assign last   = (page_q == PAGE_W'(PAGES - 1));
  assign xfer   = busy_q && out_o.ready;
  // A new frame may load as the last descriptor transfers.
  assign free_o = !busy_q || (xfer && last);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      page_q <= '0;
    end else if (desc_i.load) begin
      busy_q <= 1'b1;
      page_q <= '0;
    end else if (xfer) begin
      busy_q <= !last;
      page_q <= page_q + PAGE_W'(1);
    end
  end

  // Each page starts one image row further on.
  always_ff @(posedge clk_i) begin
    if (desc_i.load) begin
      addr_q    <= desc_i.src_addr;
      dest_q    <= desc_i.dest_column;
      cw_q      <= desc_i.copy_width;
      stopped_q <= desc_i.stopped;
    end else if (xfer) begin
      addr_q <= addr_q + ADDR_W'(stride_i);
    end
  end

  assign out_o.valid          = busy_q;
  assign out_o.page_index     = page_q;
  assign out_o.source_address = addr_q;
  assign out_o.dest_column    = dest_q;
  assign out_o.copy_width     = cw_q;
  assign out_o.last_page      = last;
  assign out_o.stopped        = stopped_q;

endmodule

[src/scrolling_window_descriptor_gen.sv]
// Top level of the scrolling window descriptor generator.
// Depends on swd_pkg, the channel interfaces, swd_cfg_regs, swd_frame and swd_page_seq.
//
// Usage:
// - cfg_i takes register writes at any time the block is idle; ready is always high.
// - in_i takes commands. A restart loads the scroll position and rate and gives
//   no descriptors. A frame tick gives eight copy descriptors on out_o, pages 0..7,
//   with last_page set on page 7, unless scrolling has stopped, in which case
//   the tick is absorbed with no output.
// - An accepted command is held in the input register; a tick waits there until the
//   page sequencer is free, which then registers its geometry and sends page 0 first.
// - Throughput: the page sequencer sends one descriptor per cycle while the receiver
//   is ready; restarts and absorbed ticks leave the input register without using it.
//   The next tick is taken into the input register while the current frame's
//   descriptors are still being sent, and its geometry loads as the last
//   descriptor transfers, so frames follow without a gap.
// - When the receiver stalls, the current descriptor holds and the input
//   register fills, after which in_i drops ready.
// - Reset clears the scroll state (position 0, rate 1, running) and sets
//   the registers to their reset values; no descriptor is pending.
module scrolling_window_descriptor_gen import swd_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  swd_cfg_if.sink   cfg_i,
  swd_in_if.sink    in_i,
  swd_out_if.source out_o
);

  cfg_t        regs;
  frame_desc_t desc;
  logic        seq_free;

  swd_cfg_regs u_cfg_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .regs_o (regs)
  );

  swd_frame u_frame (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_i),
    .regs_i     (regs),
    .seq_free_i (seq_free),
    .desc_o     (desc)
  );

  swd_page_seq u_page_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .desc_i   (desc),
    .stride_i (regs.image_width),
    .free_o   (seq_free),
    .out_o    (out_o)
  );

  // A frame may only load into the sequencer when it is free.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    desc.load |-> seq_free)
    else $error("frame loaded while the page sequencer was busy");

  // Descriptors of one frame go out back to back with rising page numbers.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.ready && !out_o.last_page
    |=> out_o.valid && (out_o.page_index == $past(out_o.page_index) + PAGE_W'(1)))
    else $error("page sequence broken within a frame");

  // Commands are only held off while descriptors are pending.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> out_o.valid)
    else $error("input stalled with no descriptor pending");

  // The first descriptor of a frame is page zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    desc.load |=> out_o.valid && (out_o.page_index == '0))
    else $error("frame did not start at page zero");

endmodule

[test/swd_descriptor_checker.sv]
`timescale 1ns / 100ps
// Scoreboard for the scrolling window descriptor generator: it tracks register
// writes and commands, predicts the copy descriptors of every frame tick and
// compares them with the output channel. Depends on swd_pkg and swd_intf.
module swd_descriptor_checker import swd_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  swd_cfg_if   cfg_mon,
  swd_in_if    cmd_mon,
  swd_out_if   desc_mon,
  output int   fail_count_o,
  output int   pending_o,
  output logic halted_o
);

  // One copy descriptor as it appears on the output channel.
  typedef struct packed {
    logic [PAGE_W-1:0] page_index;
    logic [ADDR_W-1:0] source_address;
    logic [COL_W-1:0]  dest_column;
    logic [COL_W-1:0]  copy_width;
    logic              last_page;
    logic              stopped;
  } copy_desc_t;

  // Shadow registers and scroll state.
  cfg_t                     regs;
  logic signed [POS_W-1:0]  scroll_pos;
  logic signed [RATE_W-1:0] shadow_rate;
  logic                     scroll_halted;
  copy_desc_t               expected_descs[$];

  // Compare one field and count a mismatch.
  task automatic check_field(string name, longint want, longint got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      fail_count_o++;
    end
  endtask

  // Work out the window of the current frame, queue its page descriptors and
  // advance the scroll position with the end-of-image handling.
  task automatic predict_frame();
    int         w;
    int         lm;
    int         rm;
    int         pos;
    int         next_pos;
    int         offset;
    int         cw;
    int         dest;
    longint     addr;
    copy_desc_t d;
    w        = int'(regs.image_width);
    lm       = int'(regs.left_margin);
    rm       = int'(regs.right_margin);
    pos      = int'(scroll_pos);
    next_pos = pos + int'(shadow_rate);

    // Clamp into the margins; the right bound wins when the two cross.
    if (pos < -lm) pos = -lm;
    if (pos > w + rm - SCREEN_COLUMNS) pos = w + rm - SCREEN_COLUMNS;
    offset = (pos < 0) ? 0 : pos;
    cw     = (pos < 0) ? SCREEN_COLUMNS + pos : w - offset;
    if (cw > SCREEN_COLUMNS) cw = SCREEN_COLUMNS;
    if (cw < 0) cw = 0;
    dest = (pos < 0) ? SCREEN_COLUMNS - cw : 0;

    // Bounce at the left end, then apply the end action at the right end.
    if (next_pos < -(int'(regs.left_hold) + lm)) begin
      next_pos    = -lm;
      shadow_rate = -shadow_rate;
    end
    if (next_pos > w - SCREEN_COLUMNS + int'(regs.right_hold) + rm) begin
      case (regs.end_action)
        END_LOOP: begin
          next_pos = -lm;
        end
        END_REVERSE: begin
          next_pos    = w - SCREEN_COLUMNS + rm;
          shadow_rate = -shadow_rate;
        end
        default: begin
          scroll_halted = 1'b1;
        end
      endcase
    end
    scroll_pos = next_pos[POS_W-1:0];

    for (int p = 0; p < PAGES; p++) begin
      addr             = longint'(regs.data_base) + offset + longint'(p) * w;
      d.page_index     = p[PAGE_W-1:0];
      d.source_address = addr[ADDR_W-1:0];
      d.dest_column    = dest[COL_W-1:0];
      d.copy_width     = cw[COL_W-1:0];
      d.last_page      = (p == PAGES - 1);
      d.stopped        = scroll_halted;
      expected_descs.push_back(d);
    end
  endtask

  // Watch all three channels at each rising edge.
  always @(posedge clk_i or negedge rst_ni) begin
    copy_desc_t want;
    if (!rst_ni) begin
      regs              = '0;
      regs.image_width  = 16'd128;
      regs.initial_rate = 8'sd1;
      regs.end_action   = END_ONESHOT;
      scroll_pos        = '0;
      shadow_rate       = 8'sd1;
      scroll_halted     = 1'b0;
      fail_count_o      = 0;
      expected_descs.delete();
    end else begin
      // Descriptor transfer: compare with the oldest expectation.
      if (desc_mon.valid && desc_mon.ready) begin
        if (expected_descs.size() == 0) begin
          $error("descriptor for page %0d arrived with none expected",
                 desc_mon.page_index);
          fail_count_o++;
        end else begin
          want = expected_descs.pop_front();
          check_field("page_index", want.page_index, desc_mon.page_index);
          check_field("source_address", want.source_address, desc_mon.source_address);
          check_field("dest_column", want.dest_column, desc_mon.dest_column);
          check_field("copy_width", want.copy_width, desc_mon.copy_width);
          check_field("last_page", want.last_page, desc_mon.last_page);
          check_field("stopped", want.stopped, desc_mon.stopped);
        end
      end

      // Register write transfer.
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.index)
          REG_IMAGE_WIDTH:  regs.image_width  = cfg_mon.data[IMG_W-1:0];
          REG_LEFT_MARGIN:  regs.left_margin  = cfg_mon.data[MARGIN_W-1:0];
          REG_RIGHT_MARGIN: regs.right_margin = cfg_mon.data[MARGIN_W-1:0];
          REG_LEFT_HOLD:    regs.left_hold    = cfg_mon.data[MARGIN_W-1:0];
          REG_RIGHT_HOLD:   regs.right_hold   = cfg_mon.data[MARGIN_W-1:0];
          REG_INITIAL_RATE: regs.initial_rate = cfg_mon.data[RATE_W-1:0];
          REG_END_ACTION:   regs.end_action   = cfg_mon.data[ACTION_W-1:0];
          REG_DATA_BASE:    regs.data_base    = cfg_mon.data[BASE_W-1:0];
          default: ;
        endcase
      end

      // Command transfer: a restart reloads the state, a tick makes a frame
      // unless scrolling has stopped.
      if (cmd_mon.valid && cmd_mon.ready) begin
        if (cmd_mon.command == CMD_RESTART) begin
          scroll_pos    = {cmd_mon.start_position[START_W-1], cmd_mon.start_position};
          shadow_rate   = regs.initial_rate;
          scroll_halted = 1'b0;
        end else if (!scroll_halted) begin
          predict_frame();
        end
      end
    end
    pending_o = expected_descs.size();
    halted_o  = scroll_halted;
  end

endmodule

[test/tb_scrolling_window_descriptor_gen.sv]
`timescale 1ns / 100ps
// Testbench top for the scrolling window descriptor generator: drives register
// writes and commands with random idling and stalls, and gives the verdict.
// Depends on swd_pkg, swd_intf, the block and swd_descriptor_checker.
module tb_scrolling_window_descriptor_gen;
  import swd_pkg::*;

  localparam int CYCLE_LIMIT     = 200000;
  localparam int DRAIN_CYCLES    = 16;
  localparam int PHASES_PER_MODE = 4;
  localparam int ITEMS_PER_PHASE = 34;
  // Spare end action code; the block treats it as oneshot.
  localparam logic [ACTION_W-1:0] END_SPARE = 2'd3;

  logic clk_i;
  logic rst_ni;
  int   fail_count;
  int   pending;
  logic scroll_halted;
  int   cycle_count  = 0;
  int   tx_idle_pct  = 8;
  int   rx_stall_pct = 56;

  // Copy of the geometry registers, used to aim restarts near the ends.
  int img_w = 128;
  int lmarg = 0;
  int rmarg = 0;
  int lhold = 0;
  int rhold = 0;

  swd_cfg_if cfg_if ();
  swd_in_if  cmd_if ();
  swd_out_if desc_if ();

  scrolling_window_descriptor_gen dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_if),
    .in_i   (cmd_if),
    .out_o  (desc_if)
  );

  swd_descriptor_checker desc_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_mon      (cfg_if),
    .cmd_mon      (cmd_if),
    .desc_mon     (desc_if),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .halted_o     (scroll_halted)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Guard against a hung run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Receiver stalls at random.
  always @(negedge clk_i) begin
    desc_if.ready <= ($urandom_range(0, 99) >= rx_stall_pct);
  end

  // Let every expected descriptor arrive, then let absorbed commands finish.
  task automatic settle();
    cmd_if.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  // One register write transfer; valid stays high for the caller.
  task automatic write_reg(reg_idx_e idx, logic [CFG_DATA_W-1:0] value);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    do @(posedge clk_i); while (!(cfg_if.valid && cfg_if.ready));
    @(negedge clk_i);
  endtask

  // Wait until the block is idle, then write every register.
  task automatic program_regs(int w, int lm, int rm, int lh, int rh, int rate,
                              logic [ACTION_W-1:0] action, int base);
    settle();
    img_w = w;
    lmarg = lm;
    rmarg = rm;
    lhold = lh;
    rhold = rh;
    write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(w[IMG_W-1:0]));
    write_reg(REG_LEFT_MARGIN, CFG_DATA_W'(lm[MARGIN_W-1:0]));
    write_reg(REG_RIGHT_MARGIN, CFG_DATA_W'(rm[MARGIN_W-1:0]));
    write_reg(REG_LEFT_HOLD, CFG_DATA_W'(lh[MARGIN_W-1:0]));
    write_reg(REG_RIGHT_HOLD, CFG_DATA_W'(rh[MARGIN_W-1:0]));
    write_reg(REG_INITIAL_RATE, CFG_DATA_W'(rate[RATE_W-1:0]));
    write_reg(REG_END_ACTION, CFG_DATA_W'(action));
    write_reg(REG_DATA_BASE, base[BASE_W-1:0]);
    cfg_if.valid <= 1'b0;
  endtask

  // One command transfer, after a random number of idle cycles.
  task automatic send_cmd(cmd_e cmd, int start);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      cmd_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    cmd_if.valid          <= 1'b1;
    cmd_if.command        <= cmd;
    cmd_if.start_position <= start[START_W-1:0];
    do @(posedge clk_i); while (!(cmd_if.valid && cmd_if.ready));
    @(negedge clk_i);
  endtask

  // Value in 0..top: often an extreme, often small, else uniform.
  function automatic int pick_span(int top);
    case ($urandom_range(0, 7))
      0:       return 0;
      1:       return top;
      2, 3, 4: return int'($urandom_range(0, 40));
      default: return int'($urandom_range(0, top));
    endcase
  endfunction

  // Start position near the left end, near the right end, or anywhere.
  function automatic int pick_start();
    int lo;
    int hi;
    int s;
    lo = -lmarg - lhold - 8;
    hi = img_w + rmarg + rhold - SCREEN_COLUMNS + 8;
    case ($urandom_range(0, 2))
      0:       s = lo + int'($urandom_range(0, 40));
      1:       s = hi - int'($urandom_range(0, 40));
      default: s = int'($urandom_range(0, 67583)) - 2048;
    endcase
    if (s < -2048) s = -2048;
    if (s > 65535) s = 65535;
    return s;
  endfunction

  // Random register setting, with the extremes of each field now and then.
  task automatic random_setup();
    int                  w;
    int                  rate;
    int                  base;
    logic [ACTION_W-1:0] action;
    case ($urandom_range(0, 7))
      0:       w = 0;
      1:       w = 65535;
      2:       w = int'($urandom_range(0, 65535));
      default: w = int'($urandom_range(0, 300));
    endcase
    case ($urandom_range(0, 3))
      0:       rate = int'($urandom_range(0, 255)) - 128;
      1:       rate = $urandom_range(0, 1) ? 127 : -128;
      default: rate = $urandom_range(0, 1) ? int'($urandom_range(1, 12))
                                           : -int'($urandom_range(1, 12));
    endcase
    case ($urandom_range(0, 5))
      0:       base = 0;
      1:       base = 24'hFFFFFF;
      default: base = int'($urandom_range(0, 24'hFFFFFF));
    endcase
    action = ACTION_W'($urandom_range(0, 3));
    program_regs(w, pick_span(1023), pick_span(1023), pick_span(1023),
                 pick_span(1023), rate, action, base);
  endtask

  // A restart followed mostly by ticks; a stopped scroll is restarted, with
  // an occasional absorbed tick thrown in that does not count.
  task automatic run_phase(int count);
    int done;
    send_cmd(CMD_RESTART, pick_start());
    done = 1;
    while (done < count) begin
      if (scroll_halted && $urandom_range(0, 99) < 15) begin
        send_cmd(CMD_TICK, int'($urandom_range(0, 131071)));
      end else if (scroll_halted || $urandom_range(0, 99) < 8) begin
        send_cmd(CMD_RESTART, pick_start());
        done++;
      end else begin
        send_cmd(CMD_TICK, int'($urandom_range(0, 131071)));
        done++;
      end
    end
  endtask

  initial begin
    rst_ni                = 1'b0;
    cmd_if.valid          = 1'b0;
    cmd_if.command        = CMD_RESTART;
    cmd_if.start_position = '0;
    cfg_if.valid          = 1'b0;
    cfg_if.index          = REG_IMAGE_WIDTH;
    cfg_if.data           = '0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset registers: a full window, then the lowest start position.
    send_cmd(CMD_TICK, 0);
    send_cmd(CMD_RESTART, -2048);
    send_cmd(CMD_TICK, 0);

    // All registers but the end action (reverse) at their maximum, start at both extremes.
    program_regs(65535, 1023, 1023, 1023, 1023, 127, END_REVERSE, 24'hFFFFFF);
    send_cmd(CMD_RESTART, 65535);
    send_cmd(CMD_TICK, 0);
    send_cmd(CMD_TICK, 131071);
    send_cmd(CMD_RESTART, -2048);
    send_cmd(CMD_TICK, 0);
    send_cmd(CMD_TICK, 0);

    // Zero width: the bounds cross and the copy width is zero; a rate of
    // -128 stays -128 when negated.
    program_regs(0, 0, 0, 0, 0, -128, END_REVERSE, 0);
    send_cmd(CMD_RESTART, 5);
    send_cmd(CMD_TICK, 0);

    // Oneshot stop, a tick absorbed while stopped, then a restart.
    program_regs(130, 4, 6, 2, 3, 100, END_ONESHOT, 24'h123456);
    send_cmd(CMD_RESTART, 0);
    send_cmd(CMD_TICK, 0);
    send_cmd(CMD_TICK, 0);
    send_cmd(CMD_RESTART, -10);
    send_cmd(CMD_TICK, 0);

    // Loop back to the left margin.
    program_regs(200, 20, 10, 0, 0, 60, END_LOOP, 0);
    send_cmd(CMD_RESTART, 60);
    send_cmd(CMD_TICK, 0);
    send_cmd(CMD_TICK, 0);

    // Left bounce, then the spare end action code stops like oneshot.
    program_regs(128, 0, 0, 0, 0, -5, END_SPARE, 0);
    send_cmd(CMD_RESTART, 3);
    send_cmd(CMD_TICK, 0);
    send_cmd(CMD_TICK, 0);
    send_cmd(CMD_TICK, 0);

    // Random phases under three idling patterns.
    for (int mode = 0; mode < 3; mode++) begin
      case (mode)
        0: begin
          tx_idle_pct  = 8;
          rx_stall_pct = 56;
        end
        1: begin
          tx_idle_pct  = 56;
          rx_stall_pct = 8;
        end
        default: begin
          tx_idle_pct  = 0;
          rx_stall_pct = 0;
        end
      endcase
      for (int ph = 0; ph < PHASES_PER_MODE; ph++) begin
        random_setup();
        run_phase(ITEMS_PER_PHASE);
      end
    end

    settle();
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

[scrolling_window_descriptor_gen.f]
src/swd_pkg.sv
src/swd_intf.sv
src/swd_cfg_regs.sv
src/swd_frame.sv
src/swd_page_seq.sv
src/scrolling_window_descriptor_gen.sv
test/swd_descriptor_checker.sv
test/tb_scrolling_window_descriptor_gen.sv
